/* sv/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion shorthands used by the lidar packet binner RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define LSPB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, including while reset is applied.
`define LSPB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* sv/lspb_pkg.sv */
// ============================================================================
// lspb_pkg
// Shared widths, codes and types for the lidar scan packet binner.
// ============================================================================
package lspb_pkg;

    localparam int RANGE_W       = 14;
    localparam int QUAL_W        = 6;
    localparam int ANGLE_W       = 9;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int OP_W          = 2;
    localparam int BIN_COUNT_DEF = 181;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TURN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SYNC_ERR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READOUT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY = 2'd1;

    localparam logic [OP_W-1:0] OP_PLAIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [2:0] PKT_HDR_BYTES = 3'd4;

    localparam logic [1:0] START_BITS_A = 2'b01;
    localparam logic [1:0] START_BITS_B = 2'b10;

    localparam logic [ANGLE_W-1:0] ANG_FRONT_HI = 9'd90;
    localparam logic [ANGLE_W-1:0] ANG_TURN_LO  = 9'd110;
    localparam logic [ANGLE_W-1:0] ANG_HALF     = 9'd180;
    localparam logic [ANGLE_W-1:0] ANG_BACK_HI  = 9'd250;
    localparam logic [ANGLE_W-1:0] ANG_FRONT_LO = 9'd270;
    localparam logic [ANGLE_W-1:0] ANG_FULL     = 9'd360;

    localparam logic [RANGE_W-1:0] RANGE_CAP_RST   = 14'd16383;
    localparam logic [QUAL_W-1:0]  MIN_QUALITY_RST = 6'd0;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
        logic [RANGE_W-1:0]  rng_mm;
        logic                set_seen;
        logic                clr_seen;
        logic                stop_capture;
    } decode_t;

endpackage

/* sv/lidar_scan_packet_binner.sv */
// ============================================================================
// lidar_scan_packet_binner
// Response path: a request that yields a result passes the s1 stage, then the response register.
// Throughput: one request per cycle unless the response side stalls; the bin RAM is read
// on a finished packet or a read; updates are written as they leave s1, forwarding the last write.
// Reset: asynchronous; clears control state and all bin filled flags, no clearing pass.
// ============================================================================
`include "assert_macros.svh"

module lidar_scan_packet_binner
#(
    parameter int BIN_COUNT = lspb_pkg::BIN_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lspb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lspb_pkg::RANGE_W-1:0]      cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [lspb_pkg::FUNC_W-1:0]       func,
    input  logic [7:0]                        byte_in,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [lspb_pkg::STATUS_W-1:0]     status,
    output logic [7:0]                        bin_index,
    output logic [lspb_pkg::RANGE_W-1:0]      range_value,
    output logic                              bin_valid,
    output logic                              last_bin
);
    import lspb_pkg::*;

    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam int IDX_W  = (ADDR_W > 8) ? ADDR_W : 8;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_COUNT - 1);

    logic [RANGE_W-1:0]   range_cap_reg, range_cap_next;
    logic [QUAL_W-1:0]    min_quality_reg, min_quality_next;
    logic [2:0]           byte_count_reg, byte_count_next;
    logic [3:0][7:0]      packet_reg;
    logic [BIN_COUNT-1:0] filled_reg, filled_next;
    logic                 seen_reg, seen_next;
    logic                 capture_reg, capture_next;
    logic [ADDR_W-1:0]    read_ptr_reg, read_ptr_next;
    logic [RANGE_W-1:0]   carried_range_reg, carried_range_next;
    logic                 carried_valid_reg, carried_valid_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]      s1_op_reg;
    logic [STATUS_W-1:0]  s1_status_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [RANGE_W-1:0]   s1_range_reg;
    logic                 s1_filled_reg;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  rsp_status_reg;
    logic [7:0]           rsp_index_reg;
    logic [RANGE_W-1:0]   rsp_range_reg;
    logic                 rsp_bin_valid_reg;
    logic                 rsp_last_reg;

    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [RANGE_W-1:0]   fwd_data_reg;

    logic [RANGE_W-1:0]   bin_range_mem [BIN_COUNT];
    logic [RANGE_W-1:0]   mem_rd_reg;

    decode_t              dec;
    logic [ADDR_W-1:0]    dec_addr;

    logic                 req_acc;
    logic                 cfg_acc;
    logic                 is_start;
    logic                 is_byte;
    logic                 is_read;
    logic                 byte_taken;
    logic                 pkt_store;
    logic                 pkt_done;
    logic                 s1_load;
    logic                 s1_go;
    logic [ADDR_W-1:0]    s0_addr;
    logic [OP_W-1:0]      s0_op;
    logic [STATUS_W-1:0]  s0_status;
    logic                 read_last;

    logic [RANGE_W-1:0]   stored;
    logic [RANGE_W:0]     sum;
    logic [RANGE_W-1:0]   upd_range;
    logic [RANGE_W-1:0]   rd_range;
    logic                 rd_valid;
    logic                 mem_we;
    logic [IDX_W-1:0]     idx_ext;
    logic [7:0]           out_index;
    logic [RANGE_W-1:0]   out_range;
    logic                 out_bin_valid;
    logic                 out_last;

    lspb_decode #(
        .BIN_COUNT (BIN_COUNT)
    ) u_decode (
        .pkt_bytes   (packet_reg),
        .byte_in     (byte_in),
        .seen_back   (seen_reg),
        .range_cap   (range_cap_reg),
        .min_quality (min_quality_reg),
        .dec         (dec),
        .bin_addr    (dec_addr)
    );

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign s1_go     = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_go;
    assign req_acc   = req_valid && req_ready;

    assign is_start   = (func == FUNC_START);
    assign is_byte    = (func == FUNC_BYTE);
    assign is_read    = (func == FUNC_READ);
    assign byte_taken = req_acc && is_byte && capture_reg;
    assign pkt_store  = byte_taken && (byte_count_reg < PKT_HDR_BYTES);
    assign pkt_done   = byte_taken && (byte_count_reg >= PKT_HDR_BYTES);
    assign s1_load    = pkt_done || (req_acc && is_read);
    assign read_last  = (read_ptr_reg == LAST_ADDR);

    assign s0_addr   = is_read ? read_ptr_reg : dec_addr;
    assign s0_op     = is_read ? OP_READ : dec.op;
    assign s0_status = is_read ? ST_READOUT : dec.status;

    // The last write is held so that a read issued in the same cycle still sees it.
    assign stored    = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                      : mem_rd_reg;
    assign sum       = {1'b0, stored} + {1'b0, s1_range_reg};
    assign upd_range = s1_filled_reg ? sum[RANGE_W:1] : s1_range_reg;
    assign mem_we    = s1_go && (s1_op_reg == OP_UPDATE);

    always_comb
    begin
        if (s1_filled_reg)
        begin
            rd_range = stored;
            rd_valid = 1'b1;
        end
        else if (s1_addr_reg == '0)
        begin
            rd_range = '0;
            rd_valid = 1'b0;
        end
        else
        begin
            rd_range = carried_range_reg;
            rd_valid = carried_valid_reg;
        end
    end

    assign idx_ext = IDX_W'(s1_addr_reg);

    always_comb
    begin
        case (s1_op_reg)
            OP_UPDATE:
            begin
                out_index     = idx_ext[7:0];
                out_range     = upd_range;
                out_bin_valid = 1'b1;
                out_last      = 1'b0;
            end
            OP_READ:
            begin
                out_index     = idx_ext[7:0];
                out_range     = rd_range;
                out_bin_valid = rd_valid;
                out_last      = (s1_addr_reg == LAST_ADDR);
            end
            default:
            begin
                out_index     = '0;
                out_range     = '0;
                out_bin_valid = 1'b0;
                out_last      = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        range_cap_next     = range_cap_reg;
        min_quality_next   = min_quality_reg;
        byte_count_next    = byte_count_reg;
        filled_next        = filled_reg;
        seen_next          = seen_reg;
        capture_next       = capture_reg;
        read_ptr_next      = read_ptr_reg;
        carried_range_next = carried_range_reg;
        carried_valid_next = carried_valid_reg;

        if (cfg_acc)
        begin
            case (cfg_index)
                CFG_RANGE_CAP:   range_cap_next   = cfg_data;
                CFG_MIN_QUALITY: min_quality_next = cfg_data[QUAL_W-1:0];
                default:         range_cap_next   = range_cap_reg;
            endcase
        end

        if (s1_go && s1_op_reg == OP_READ)
        begin
            carried_range_next = rd_range;
            carried_valid_next = rd_valid;
        end

        if (pkt_store)
        begin
            byte_count_next = byte_count_reg + 3'd1;
        end

        if (pkt_done)
        begin
            byte_count_next = '0;
            if (dec.set_seen)
            begin
                seen_next = 1'b1;
            end
            if (dec.clr_seen)
            begin
                seen_next = 1'b0;
            end
            if (dec.stop_capture)
            begin
                capture_next = 1'b0;
            end
            if (dec.op == OP_UPDATE)
            begin
                filled_next[dec_addr] = 1'b1;
            end
        end

        if (req_acc && is_read)
        begin
            read_ptr_next = read_last ? '0 : read_ptr_reg + ADDR_W'(1);
        end

        if (req_acc && is_start)
        begin
            filled_next        = '0;
            byte_count_next    = '0;
            read_ptr_next      = '0;
            carried_range_next = '0;
            carried_valid_next = 1'b0;
            capture_next       = 1'b1;
        end
    end

    always_comb
    begin
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_cap_reg     <= RANGE_CAP_RST;
            min_quality_reg   <= MIN_QUALITY_RST;
            byte_count_reg    <= '0;
            filled_reg        <= '0;
            seen_reg          <= 1'b0;
            capture_reg       <= 1'b0;
            read_ptr_reg      <= '0;
            carried_range_reg <= '0;
            carried_valid_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            fwd_valid_reg     <= 1'b0;
        end
        else
        begin
            range_cap_reg     <= range_cap_next;
            min_quality_reg   <= min_quality_next;
            byte_count_reg    <= byte_count_next;
            filled_reg        <= filled_next;
            seen_reg          <= seen_next;
            capture_reg       <= capture_next;
            read_ptr_reg      <= read_ptr_next;
            carried_range_reg <= carried_range_next;
            carried_valid_reg <= carried_valid_next;
            s1_valid_reg      <= s1_valid_next;
            rsp_valid_reg     <= rsp_valid_next;
            if (mem_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_store)
        begin
            packet_reg[byte_count_reg[1:0]] <= byte_in;
        end
        if (s1_load)
        begin
            s1_op_reg     <= s0_op;
            s1_status_reg <= s0_status;
            s1_addr_reg   <= s0_addr;
            s1_range_reg  <= dec.rng_mm;
            s1_filled_reg <= filled_reg[s0_addr];
        end
        if (s1_go)
        begin
            rsp_status_reg    <= s1_status_reg;
            rsp_index_reg     <= out_index;
            rsp_range_reg     <= out_range;
            rsp_bin_valid_reg <= out_bin_valid;
            rsp_last_reg      <= out_last;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= upd_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_range_mem[s1_addr_reg] <= upd_range;
        end
        if (s1_load)
        begin
            mem_rd_reg <= bin_range_mem[s0_addr];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign bin_index   = rsp_index_reg;
    assign range_value = rsp_range_reg;
    assign bin_valid   = rsp_bin_valid_reg;
    assign last_bin    = rsp_last_reg;

    `LSPB_ASSERT(a_s1_hold, s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_addr_reg), "stalled bin stage lost its request")
    `LSPB_ASSERT(a_stall_cause, !req_ready |-> s1_valid_reg && rsp_valid_reg && !rsp_ready, "request stalled without a full pipeline")
    `LSPB_ASSERT(a_start_clears, req_acc && is_start |=> filled_reg == '0 && read_ptr_reg == '0, "start request did not clear the bins")
    `LSPB_ASSERT(a_ptr_range, {1'b0, read_ptr_reg} < (ADDR_W + 1)'(BIN_COUNT), "read pointer beyond last bin")
    `LSPB_ASSERT(a_count_range, byte_count_reg <= PKT_HDR_BYTES, "packet byte count overran")

endmodule

/* sv/lspb_decode.sv */
// ============================================================================
// lspb_decode
// Checks a completed 5-byte measurement packet and classifies the point.
// ============================================================================
module lspb_decode
#(
    parameter int BIN_COUNT = lspb_pkg::BIN_COUNT_DEF
)
(
    input  logic [3:0][7:0]                  pkt_bytes,
    input  logic [7:0]                       byte_in,
    input  logic                             seen_back,
    input  logic [lspb_pkg::RANGE_W-1:0]     range_cap,
    input  logic [lspb_pkg::QUAL_W-1:0]      min_quality,
    output lspb_pkg::decode_t                dec,
    output logic [$clog2(BIN_COUNT)-1:0]     bin_addr
);
    import lspb_pkg::*;

    localparam int ADDR_W = $clog2(BIN_COUNT);

    logic [ANGLE_W-1:0] angle;
    logic [QUAL_W-1:0]  quality;
    logic [1:0]         start_bits;
    logic               sync_ok;
    logic [RANGE_W-1:0] range_raw;
    logic [RANGE_W-1:0] range_sat;
    logic [ANGLE_W-1:0] bin9;
    logic               bin_ok;
    logic               front;

    assign angle      = {pkt_bytes[2], pkt_bytes[1][7]};
    assign quality    = pkt_bytes[0][7:2];
    assign start_bits = pkt_bytes[0][1:0];
    assign sync_ok    = (start_bits == START_BITS_A || start_bits == START_BITS_B)
                        && pkt_bytes[1][0] && (angle < ANG_FULL);
    assign range_raw  = {byte_in, pkt_bytes[3][7:2]};
    assign range_sat  = (range_raw > range_cap) ? range_cap : range_raw;
    assign bin9       = (angle <= ANG_FRONT_HI) ? (angle + ANG_FRONT_HI)
                                                : (angle - ANG_FRONT_LO);
    assign bin_ok     = {1'b0, bin9} < (ANGLE_W + 1)'(BIN_COUNT);
    assign front      = (angle >= ANG_FRONT_LO) || (angle <= ANG_FRONT_HI);
    assign bin_addr   = ADDR_W'(bin9);

    always_comb
    begin
        dec        = '0;
        dec.op     = OP_PLAIN;
        dec.status = ST_IGNORED;
        if (!sync_ok)
        begin
            dec.status       = ST_SYNC_ERR;
            dec.stop_capture = 1'b1;
        end
        else if (angle > ANG_BACK_HI || angle < ANG_TURN_LO)
        begin
            if (front && seen_back && quality >= min_quality && bin_ok)
            begin
                dec.op     = OP_UPDATE;
                dec.status = ST_UPDATED;
                dec.rng_mm = range_sat;
            end
        end
        else if (angle > ANG_HALF)
        begin
            dec.set_seen = 1'b1;
        end
        else if (seen_back)
        begin
            dec.clr_seen     = 1'b1;
            dec.stop_capture = 1'b1;
            dec.status       = ST_TURN;
        end
    end

endmodule

/* verif/tb_lidar_scan_packet_binner.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_lidar_scan_packet_binner
// Self-checking bench for the lidar scan packet binner. Whole scans are sent
// as byte requests: a start, a back-quarter packet, front points with random
// angle, quality and range, broken and stray bytes, a turn-ending packet,
// and bin readouts. A tracker keeps its own copy of the bins and the packet
// framing state and compares every response field with its prediction.
// Limits are changed between phases while the block is idle, and both sides
// of the request and response handshakes pause at random.
// ============================================================================
module tb_lidar_scan_packet_binner;
    import lspb_pkg::*;

    localparam int BINS = BIN_COUNT_DEF;
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [7:0]          idx;
        logic [RANGE_W-1:0]  rng;
        logic                ok;
        logic                last;
    } bin_result_t;

    typedef enum {FLAW_NONE, FLAW_START, FLAW_CHECK, FLAW_ANGLE, FLAW_NOISE} flaw_t;

    class scan_bin_tracker;
        logic [RANGE_W-1:0] max_rng;
        logic [QUAL_W-1:0]  min_qual;
        int                 byte_cnt;
        logic [7:0]         pkt [4];
        logic [RANGE_W-1:0] bin_rng [BINS];
        bit                 bin_set [BINS];
        bit                 seen_back;
        bit                 capture_on;
        int                 rd_ptr;
        logic [RANGE_W-1:0] carry_rng;
        bit                 carry_ok;
        bin_result_t        pending_bins [$];
        int                 mismatches;

        function new();
            max_rng = RANGE_CAP_RST;
            min_qual = MIN_QUALITY_RST;
            byte_cnt = 0;
            foreach (bin_set[i]) bin_set[i] = 1'b0;
            seen_back = 1'b0;
            capture_on = 1'b0;
            rd_ptr = 0;
            carry_rng = '0;
            carry_ok = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] data);
            if (idx == CFG_RANGE_CAP)
                max_rng = data;
            else if (idx == CFG_MIN_QUALITY)
                min_qual = data[QUAL_W-1:0];
        endfunction

        function bin_result_t decode_packet(logic [7:0] b4);
            bin_result_t r;
            logic [1:0]  lead;
            int          ang;
            int          qual;
            int          bin;
            int          rng;
            r = '{ST_IGNORED, 8'd0, '0, 1'b0, 1'b0};
            lead = pkt[0][1:0];
            ang = {pkt[2], pkt[1][7]};
            qual = pkt[0][7:2];
            if (!((lead == START_BITS_A || lead == START_BITS_B) && pkt[1][0]
                  && ang < ANG_FULL)) begin
                capture_on = 1'b0;
                r.status = ST_SYNC_ERR;
                return r;
            end
            if (ang > ANG_BACK_HI || ang < ANG_TURN_LO) begin
                if ((ang >= ANG_FRONT_LO || ang <= ANG_FRONT_HI) && seen_back
                    && qual >= min_qual) begin
                    bin = (ang <= ANG_FRONT_HI) ? ang + ANG_FRONT_HI : ang - ANG_FRONT_LO;
                    rng = {b4, pkt[3]};
                    rng = rng >> 2;
                    if (rng > max_rng)
                        rng = max_rng;
                    if (bin < BINS) begin
                        if (bin_set[bin])
                            rng = (bin_rng[bin] + rng) >> 1;
                        bin_rng[bin] = rng[RANGE_W-1:0];
                        bin_set[bin] = 1'b1;
                        r = '{ST_UPDATED, bin[7:0], rng[RANGE_W-1:0], 1'b1, 1'b0};
                    end
                end
            end else if (ang > ANG_HALF) begin
                seen_back = 1'b1;
            end else if (seen_back) begin
                seen_back = 1'b0;
                capture_on = 1'b0;
                r.status = ST_TURN;
            end
            return r;
        endfunction

        // Returns 1 when the request did any work in the block.
        function bit note_request(logic [FUNC_W-1:0] f, logic [7:0] b);
            int  i;
            bit  last;
            case (f)
                FUNC_START: begin
                    foreach (bin_set[k]) bin_set[k] = 1'b0;
                    byte_cnt = 0;
                    rd_ptr = 0;
                    carry_rng = '0;
                    carry_ok = 1'b0;
                    capture_on = 1'b1;
                    return 1'b1;
                end
                FUNC_BYTE: begin
                    if (!capture_on)
                        return 1'b0;
                    if (byte_cnt < PKT_HDR_BYTES) begin
                        pkt[byte_cnt] = b;
                        byte_cnt++;
                    end else begin
                        byte_cnt = 0;
                        pending_bins.push_back(decode_packet(b));
                    end
                    return 1'b1;
                end
                FUNC_READ: begin
                    i = (rd_ptr >= BINS) ? 0 : rd_ptr;
                    if (bin_set[i]) begin
                        carry_rng = bin_rng[i];
                        carry_ok = 1'b1;
                    end else if (i == 0) begin
                        carry_rng = '0;
                        carry_ok = 1'b0;
                    end
                    last = (i == BINS - 1);
                    pending_bins.push_back('{ST_READOUT, i[7:0], carry_rng, carry_ok, last});
                    rd_ptr = last ? 0 : i + 1;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_response(logic [STATUS_W-1:0] st, logic [7:0] idx,
                            logic [RANGE_W-1:0] rng, logic ok, logic last);
            bin_result_t e;
            if (pending_bins.size() == 0) begin
                report_mismatch($sformatf("response with status %0d and none outstanding", st));
                return;
            end
            e = pending_bins.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (idx !== e.idx)
                report_mismatch($sformatf("bin_index %0d, expected %0d", idx, e.idx));
            if (rng !== e.rng)
                report_mismatch($sformatf("range_value %0d, expected %0d", rng, e.rng));
            if (ok !== e.ok)
                report_mismatch($sformatf("bin_valid %0b, expected %0b", ok, e.ok));
            if (last !== e.last)
                report_mismatch($sformatf("last_bin %0b, expected %0b", last, e.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RANGE_CAP;
    logic [RANGE_W-1:0]    cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [FUNC_W-1:0]     func = FUNC_START;
    logic [7:0]            byte_in = 8'd0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [7:0]            bin_index;
    logic [RANGE_W-1:0]    range_value;
    logic                  bin_valid;
    logic                  last_bin;

    scan_bin_tracker tracker = new();
    int  done_items = 0;
    bit  no_gaps = 1'b0;
    bit  hold_rsp = 1'b0;

    lidar_scan_packet_binner #(.BIN_COUNT(BINS)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .byte_in     (byte_in),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .bin_index   (bin_index),
        .range_value (range_value),
        .bin_valid   (bin_valid),
        .last_bin    (last_bin)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_response(status, bin_index, range_value, bin_valid, last_bin);
    end

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        byte_in <= b;
        do @(posedge clk); while (!req_ready);
        void'(tracker.note_request(f, b));
        done_items++;
    endtask

    task automatic send_packet(input int ang, input int qual, input logic [15:0] raw,
                               input flaw_t flaw);
        logic [7:0] pb [5];
        logic [1:0] lead;
        logic       chk;
        lead = $urandom_range(0, 1) ? START_BITS_A : START_BITS_B;
        chk = 1'b1;
        case (flaw)
            FLAW_START: lead = {2{1'($urandom)}};
            FLAW_CHECK: chk = 1'b0;
            FLAW_ANGLE: ang = $urandom_range(360, 511);
            default: ;
        endcase
        pb[0] = {qual[5:0], lead};
        pb[1] = {ang[0], 6'($urandom), chk};
        pb[2] = ang[8:1];
        pb[3] = raw[7:0];
        pb[4] = raw[15:8];
        if (flaw == FLAW_NOISE)
            foreach (pb[i]) pb[i] = 8'($urandom);
        foreach (pb[i]) send_req(FUNC_BYTE, pb[i]);
    endtask

    function automatic logic [15:0] draw_raw();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int draw_quality();
        return ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 63);
    endfunction

    task automatic read_bins(input int n);
        repeat (n) send_req(FUNC_READ, 8'($urandom));
    endtask

    task automatic run_scan();
        int n_pts;
        int pick;
        int ang;
        int prev_ang;
        no_gaps = ($urandom_range(0, 3) == 0);
        prev_ang = 0;
        send_req(FUNC_START, 8'($urandom));
        if ($urandom_range(0, 9) != 0)
            send_packet($urandom_range(181, 250), draw_quality(), draw_raw(), FLAW_NONE);
        n_pts = $urandom_range(4, 30);
        repeat (n_pts)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 3) == 0)
                    ang = prev_ang;
                else
                    ang = $urandom_range(0, 1) ? $urandom_range(0, 90) : $urandom_range(270, 359);
                prev_ang = ang;
                send_packet(ang, draw_quality(), draw_raw(), FLAW_NONE);
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 2))
                    0: ang = $urandom_range(91, 109);
                    1: ang = $urandom_range(251, 269);
                    default: ang = $urandom_range(181, 250);
                endcase
                send_packet(ang, draw_quality(), draw_raw(), FLAW_NONE);
            end
            else if (pick < 86)
                send_packet(0, draw_quality(), draw_raw(), flaw_t'($urandom_range(1, 4)));
            else if (pick < 90)
                send_req(FUNC_BYTE, 8'($urandom));
            else if (pick < 93)
                send_req(FUNC_RSVD, 8'($urandom));
            else if (pick < 97)
                send_req(FUNC_READ, 8'($urandom));
            else
                send_req(FUNC_START, 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0)
            send_packet($urandom_range(110, 180), draw_quality(), draw_raw(), FLAW_NONE);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            read_bins($urandom_range(1, 30));
        else if (pick < 9)
            read_bins(BINS);
        else
            read_bins($urandom_range(150, 200));
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (tracker.pending_bins.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_limits(input logic [RANGE_W-1:0] rng_cap, input logic [QUAL_W-1:0] floor_q);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RANGE_CAP;
        cfg_data <= rng_cap;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_RANGE_CAP, rng_cap);
        cfg_index <= CFG_MIN_QUALITY;
        cfg_data <= RANGE_W'(floor_q);
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_MIN_QUALITY, RANGE_W'(floor_q));
        cfg_valid <= 1'b0;
    endtask

    // The receiver stalls per response; once a long hold is requested it keeps
    // rsp_ready low so the block backs up into the request side.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_limits(RANGE_CAP_RST, MIN_QUALITY_RST);

        send_req(FUNC_RSVD, 8'hFF);
        send_req(FUNC_BYTE, 8'h00);
        send_req(FUNC_READ, 8'h00);
        send_req(FUNC_START, 8'h00);
        send_packet(250, 0, 16'h0000, FLAW_NONE);
        send_packet(90, 63, 16'hFFFF, FLAW_NONE);
        send_packet(270, 0, 16'h0000, FLAW_NONE);
        send_packet(110, 63, 16'hFFFF, FLAW_NONE);
        send_req(FUNC_READ, 8'hFF);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: set_limits(RANGE_W'($urandom_range(0, 16383)), QUAL_W'($urandom_range(0, 63)));
                1: set_limits('0, '1);
                2: set_limits('1, '0);
                3: set_limits(14'd1000, 6'd32);
                4: set_limits(RANGE_W'($urandom_range(0, 4000)), '0);
                default: set_limits('1, QUAL_W'($urandom_range(40, 63)));
            endcase
            if (p == 2)
                hold_rsp = 1'b1;
            while (done_items < 25 + (p + 1) * 255)
                run_scan();
        end

        req_valid <= 1'b0;
        while (tracker.pending_bins.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* lidar_scan_packet_binner.f */
+incdir+sv
sv/lspb_pkg.sv
sv/lspb_decode.sv
sv/lidar_scan_packet_binner.sv
verif/tb_lidar_scan_packet_binner.sv
